/* design/spsg_pkg.sv */
// Shared constants, codes and types for the segmented prime sieve.
`default_nettype none

package spsg_pkg;

  localparam int unsigned SEGMENT_SIZE = 4096;
  localparam int unsigned NUMBER_WIDTH = 44;
  localparam int unsigned PRIME_WIDTH  = 22;
  localparam int unsigned LEN_W        = 13;
  localparam int unsigned GAP_W        = 16;

  // Mark memory: one bit per cell, ROW_W cells per row.
  localparam int unsigned ROW_W  = 64;
  localparam int unsigned BIT_W  = $clog2(ROW_W);
  localparam int unsigned ROWS   = SEGMENT_SIZE / ROW_W;
  localparam int unsigned ROW_AW = $clog2(ROWS);

  // Cursor and cell index hold 0..SEGMENT_SIZE.
  localparam int unsigned CUR_W = $clog2(SEGMENT_SIZE) + 1;
  // Strike offset: below the length plus one prime.
  localparam int unsigned OFF_W = PRIME_WIDTH + 1;

  // Remainder unit: DIV_BITS quotient bits per cycle.
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_CYCLES = (NUMBER_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned DIV_PAD    = DIV_CYCLES * DIV_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

  typedef enum logic [1:0] {
    OP_OPEN   = 2'd0,
    OP_STRIKE = 2'd1,
    OP_NEXT   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_LOAD,
    ST_CLEAR,
    ST_SCAN,
    ST_NUM,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

/* design/spsg_if.sv */
// Valid/ready channels for request and result words.
`default_nettype none

interface spsg_in_if import spsg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic [NUMBER_WIDTH-1:0] segment_base;
  logic [LEN_W-1:0]        segment_length;
  logic [PRIME_WIDTH-1:0]  base_prime;

  modport source (
    output valid, opcode, segment_base, segment_length, base_prime,
    input  ready
  );
  modport sink (
    input  valid, opcode, segment_base, segment_length, base_prime,
    output ready
  );
endinterface

interface spsg_out_if import spsg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [NUMBER_WIDTH-1:0] prime_number;
  logic [GAP_W-1:0]        prime_gap;
  logic                    segment_done;

  modport source (
    output valid, prime_number, prime_gap, segment_done,
    input  ready
  );
  modport sink (
    input  valid, prime_number, prime_gap, segment_done,
    output ready
  );
endinterface

`default_nettype wire

/* design/spsg_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module spsg_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/segmented_prime_sieve_gaps_core.sv */
// Segmented sieve core: mark memory, strike walker, survivor scan, gap output.
//
//   channel  dir  handshake          word
//   in_i     in   valid/ready        opcode, segment_base, segment_length, base_prime
//   out_o    out  valid/ready        prime_number, prime_gap, segment_done
//
// One request at a time; in_i.ready is high only when the sequencer is idle.
// Open: row valid bits are cleared at once, no memory sweep.
// Strike: ST_DIV (remainder unit, 4 bits/cycle), ST_SETUP, then one ST_CLEAR per
//   cleared cell plus one ST_LOAD per 64-bit mark row touched (row load before read-modify-write).
// Next: ST_SCAN per 64-cell row scanned, then ST_NUM and ST_EMIT; waits only if the output
//   register still holds an untaken word. No clearing pass after reset.
`default_nettype none

module segmented_prime_sieve_gaps_core import spsg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  spsg_in_if.sink    in_i,
  spsg_out_if.source out_o
);

  state_e state_q, state_d;

  logic [NUMBER_WIDTH-1:0] base_q, base_d;
  logic [CUR_W-1:0]        len_q, len_d;
  logic [CUR_W-1:0]        cursor_q, cursor_d;
  logic [NUMBER_WIDTH-1:0] prev_q, prev_d;
  logic [ROWS-1:0]         rvalid_q, rvalid_d;
  logic                    done_q, done_d;
  logic                    out_valid_q, out_valid_d;

  logic [PRIME_WIDTH-1:0]  p_q, p_d;
  logic [PRIME_WIDTH-1:0]  rem_q, rem_d;
  logic [NUMBER_WIDTH-1:0] sq_q, sq_d;
  logic [DIV_PAD-1:0]      divd_q, divd_d;
  logic [DIV_CNT_W-1:0]    div_cnt_q, div_cnt_d;
  logic [OFF_W-1:0]        off_q, off_d;
  logic [ROW_AW-1:0]       row_q, row_d;
  logic [ROW_W-1:0]        buf_q, buf_d;
  logic [CUR_W-1:0]        idx_q, idx_d;
  logic [NUMBER_WIDTH-1:0] num_q, num_d;
  logic [NUMBER_WIDTH-1:0] out_num_q, out_num_d;
  logic [GAP_W-1:0]        out_gap_q, out_gap_d;
  logic                    out_done_q, out_done_d;

  logic                    mem_we, mem_re;
  logic [ROW_AW-1:0]       mem_waddr, mem_raddr;
  logic [ROW_W-1:0]        mem_wdata, mem_rdata;

  logic                      in_acc, slot_free;
  logic [2*PRIME_WIDTH-1:0]  sq_prod;
  logic [NUMBER_WIDTH-1:0]   sq_diff;
  logic                      sq_ge, sq_gt, strike_skip;
  logic [PRIME_WIDTH-1:0]    rem_off;
  logic [OFF_W-1:0]          sq_off, strike_start;
  logic [ROW_W-1:0]          buf_clr;
  logic [OFF_W-1:0]          off_nx;
  logic                      nx_in;
  logic [ROW_AW-1:0]         nx_row, cur_row;
  logic [ROW_W-1:0]          scan_row, scan_mask;
  logic                      scan_hit;
  logic [BIT_W-1:0]          scan_bit;
  logic [CUR_W-1:0]          row_next;
  logic [NUMBER_WIDTH-1:0]   gap_diff;
  logic [GAP_W-1:0]          gap_val;

  spsg_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_marks (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Restoring remainder, DIV_BITS dividend bits per call.
  function automatic logic [PRIME_WIDTH-1:0] div_step(
    input logic [PRIME_WIDTH-1:0] rem,
    input logic [DIV_BITS-1:0]    bits,
    input logic [PRIME_WIDTH-1:0] p
  );
    logic [PRIME_WIDTH:0]   t;
    logic [PRIME_WIDTH-1:0] r;
    r = rem;
    for (int k = 0; k < DIV_BITS; k++) begin
      t = {r, bits[DIV_BITS-1-k]};
      if (t >= {1'b0, p}) begin
        t = t - {1'b0, p};
      end
      r = t[PRIME_WIDTH-1:0];
    end
    return r;
  endfunction

  assign in_acc    = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign sq_prod   = (2*PRIME_WIDTH)'(in_i.base_prime) * (2*PRIME_WIDTH)'(in_i.base_prime);

  // Strike start offset.
  assign sq_diff     = sq_q - base_q;
  assign sq_ge       = sq_q >= base_q;
  assign sq_gt       = sq_q > base_q;
  assign strike_skip = sq_ge && (sq_diff >= NUMBER_WIDTH'(len_q));
  assign rem_off     = (rem_q == '0) ? '0 : p_q - rem_q;
  // Only used when not skipped, so the difference is below the length.
  assign sq_off      = OFF_W'(sq_diff[CUR_W-1:0]);
  assign strike_start = (sq_gt && sq_off > OFF_W'(rem_off)) ? sq_off : OFF_W'(rem_off);

  // Strike walk.
  assign buf_clr = buf_q & ~(ROW_W'(1) << off_q[BIT_W-1:0]);
  assign off_nx  = off_q + OFF_W'(p_q);
  assign nx_in   = off_nx < OFF_W'(len_q);
  assign nx_row  = off_nx[BIT_W +: ROW_AW];

  // Survivor scan over the row at the cursor.
  assign cur_row  = cursor_q[BIT_W +: ROW_AW];
  assign scan_row = rvalid_q[cur_row] ? mem_rdata : '1;
  assign row_next = CUR_W'({cur_row, BIT_W'(0)}) + CUR_W'(ROW_W);

  always_comb begin
    for (int b = 0; b < ROW_W; b++) begin
      scan_mask[b] = scan_row[b] && (BIT_W'(b) >= cursor_q[BIT_W-1:0]) &&
                     (CUR_W'({cur_row, BIT_W'(b)}) < len_q);
    end
  end

  always_comb begin
    scan_hit = 1'b0;
    scan_bit = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (scan_mask[b]) begin
        scan_hit = 1'b1;
        scan_bit = BIT_W'(b);
      end
    end
  end

  assign gap_diff = num_q - prev_q;
  assign gap_val  = (num_q < prev_q) ? '0 :
                    (|gap_diff[NUMBER_WIDTH-1:GAP_W]) ? '1 : gap_diff[GAP_W-1:0];

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    len_d       = len_q;
    cursor_d    = cursor_q;
    prev_d      = prev_q;
    rvalid_d    = rvalid_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;
    p_d         = p_q;
    rem_d       = rem_q;
    sq_d        = sq_q;
    divd_d      = divd_q;
    div_cnt_d   = div_cnt_q;
    off_d       = off_q;
    row_d       = row_q;
    buf_d       = buf_q;
    idx_d       = idx_q;
    num_d       = num_q;
    out_num_d   = out_num_q;
    out_gap_d   = out_gap_q;
    out_done_d  = out_done_q;
    mem_we      = 1'b0;
    mem_waddr   = row_q;
    mem_wdata   = buf_clr;
    mem_re      = 1'b0;
    mem_raddr   = cur_row;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (op_e'(in_i.opcode))
            OP_OPEN: begin
              base_d   = in_i.segment_base;
              len_d    = (CUR_W'(in_i.segment_length) > CUR_W'(SEGMENT_SIZE)) ?
                         CUR_W'(SEGMENT_SIZE) : CUR_W'(in_i.segment_length);
              cursor_d = '0;
              rvalid_d = '0;
            end
            OP_STRIKE: begin
              if (in_i.base_prime > PRIME_WIDTH'(1)) begin
                p_d       = in_i.base_prime;
                sq_d      = NUMBER_WIDTH'(sq_prod);
                rem_d     = '0;
                divd_d    = DIV_PAD'(base_q);
                div_cnt_d = '0;
                state_d   = ST_DIV;
              end
            end
            OP_NEXT: begin
              if (cursor_q >= len_q) begin
                done_d  = 1'b1;
                state_d = ST_EMIT;
              end else begin
                done_d  = 1'b0;
                mem_re  = 1'b1;
                state_d = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_DIV: begin
        rem_d     = div_step(rem_q, divd_q[DIV_PAD-1 -: DIV_BITS], p_q);
        divd_d    = divd_q << DIV_BITS;
        div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
        if (div_cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          state_d = ST_SETUP;
        end
      end

      ST_SETUP: begin
        if (strike_skip || strike_start >= OFF_W'(len_q)) begin
          state_d = ST_IDLE;
        end else begin
          off_d     = strike_start;
          row_d     = strike_start[BIT_W +: ROW_AW];
          mem_re    = 1'b1;
          mem_raddr = strike_start[BIT_W +: ROW_AW];
          state_d   = ST_LOAD;
        end
      end

      ST_LOAD: begin
        buf_d   = rvalid_q[row_q] ? mem_rdata : '1;
        state_d = ST_CLEAR;
      end

      ST_CLEAR: begin
        // Clears stay in the row buffer until the walk leaves the row.
        off_d = off_nx;
        if (nx_in && nx_row == row_q) begin
          buf_d = buf_clr;
        end else begin
          mem_we          = 1'b1;
          rvalid_d[row_q] = 1'b1;
          if (nx_in) begin
            mem_re    = 1'b1;
            mem_raddr = nx_row;
            row_d     = nx_row;
            state_d   = ST_LOAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_SCAN: begin
        if (scan_hit) begin
          idx_d   = CUR_W'({cur_row, scan_bit});
          state_d = ST_NUM;
        end else if (row_next >= len_q) begin
          cursor_d = len_q;
          done_d   = 1'b1;
          state_d  = ST_EMIT;
        end else begin
          cursor_d  = row_next;
          mem_re    = 1'b1;
          mem_raddr = row_next[BIT_W +: ROW_AW];
        end
      end

      ST_NUM: begin
        num_d    = base_q + NUMBER_WIDTH'(idx_q);
        cursor_d = idx_q + CUR_W'(1);
        state_d  = ST_EMIT;
      end

      ST_EMIT: begin
        if (done_q) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_num_d   = '0;
            out_gap_d   = '0;
            out_done_d  = 1'b1;
            cursor_d    = len_q;
            done_d      = 1'b0;
            state_d     = ST_IDLE;
          end
        end else if (num_q < NUMBER_WIDTH'(2)) begin
          // Zero and one are not prime: resume the scan past them.
          if (cursor_q >= len_q) begin
            done_d = 1'b1;
          end else begin
            mem_re  = 1'b1;
            state_d = ST_SCAN;
          end
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          out_num_d   = num_q;
          out_gap_d   = gap_val;
          out_done_d  = 1'b0;
          prev_d      = num_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      len_q       <= '0;
      cursor_q    <= '0;
      prev_q      <= '0;
      rvalid_q    <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      len_q       <= len_d;
      cursor_q    <= cursor_d;
      prev_q      <= prev_d;
      rvalid_q    <= rvalid_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    rem_q      <= rem_d;
    sq_q       <= sq_d;
    divd_q     <= divd_d;
    div_cnt_q  <= div_cnt_d;
    off_q      <= off_d;
    row_q      <= row_d;
    buf_q      <= buf_d;
    idx_q      <= idx_d;
    num_q      <= num_d;
    out_num_q  <= out_num_d;
    out_gap_q  <= out_gap_d;
    out_done_q <= out_done_d;
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.prime_number = out_num_q;
  assign out_o.prime_gap    = out_gap_q;
  assign out_o.segment_done = out_done_q;

`ifndef SYNTH
  a_cursor_in_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= len_q)
    else $error("scan cursor beyond segment length");

  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CUR_W'(SEGMENT_SIZE))
    else $error("segment length above capacity");

  a_walk_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |->
      (off_q < OFF_W'(len_q)) && (off_q[BIT_W +: ROW_AW] == row_q))
    else $error("strike walk outside buffered row or segment");

  a_done_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.segment_done) |->
      (out_o.prime_number == '0) && (out_o.prime_gap == '0))
    else $error("done word carries a number or gap");

  a_prev_tracks_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !done_q && num_q >= NUMBER_WIDTH'(2) && slot_free) |=>
      (out_o.valid && prev_q == out_o.prime_number))
    else $error("previous prime not updated with reported survivor");
`endif

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the segmented prime sieve core.
`default_nettype none

module tb;
  import spsg_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned SIEVED_WORDS = 850;
  localparam int unsigned TOTAL_WORDS  = 1125;
  localparam longint unsigned NUM_MASK = (64'd1 << NUMBER_WIDTH) - 64'd1;
  localparam longint unsigned GAP_MAX  = (64'd1 << GAP_W) - 64'd1;

  typedef struct packed {
    logic [NUMBER_WIDTH-1:0] number;
    logic [GAP_W-1:0]        gap;
    logic                    done;
  } prime_word_t;

  logic clk;
  logic rst_n;

  spsg_in_if  in_if ();
  spsg_out_if out_if ();

  segmented_prime_sieve_gaps_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Predicted sieve state
  bit              sieve_marks [SEGMENT_SIZE];
  longint unsigned seg_base;
  int unsigned     seg_len;
  int unsigned     scan_pos;
  longint unsigned last_prime;

  prime_word_t     pending_primes [$];
  prime_word_t     want;
  int unsigned     small_primes [$];
  int unsigned     words_sent;
  int unsigned     mismatches;
  int unsigned     quiet_cycles;
  bit              last_done;
  bit              no_idle;
  bit              hold_req;

  function automatic void sieve_open(longint unsigned base, int unsigned len);
    seg_base = base & NUM_MASK;
    seg_len  = (len > SEGMENT_SIZE) ? SEGMENT_SIZE : len;
    scan_pos = 0;
    for (int unsigned i = 0; i < SEGMENT_SIZE; i++) sieve_marks[i] = 1'b1;
    // 0 and 1 are never prime, even after the base wraps
    for (int unsigned i = 0; i < seg_len; i++) begin
      if (((seg_base + i) & NUM_MASK) < 2) sieve_marks[i] = 1'b0;
    end
  endfunction

  function automatic void sieve_strike(longint unsigned p);
    longint unsigned sq;
    longint unsigned rem;
    longint unsigned off;
    if (p < 2) return;
    sq = p * p;
    if (sq >= seg_base && sq - seg_base >= seg_len) return;
    rem = seg_base % p;
    off = (rem == 0) ? 0 : p - rem;
    if (sq > seg_base && sq - seg_base > off) off = sq - seg_base;
    while (off < seg_len) begin
      sieve_marks[off] = 1'b0;
      off += p;
    end
  endfunction

  function automatic prime_word_t sieve_next_prime();
    prime_word_t     w;
    int unsigned     i;
    longint unsigned num;
    longint unsigned gap;
    i = scan_pos;
    while (i < seg_len && !sieve_marks[i]) i++;
    if (i >= seg_len) begin
      scan_pos = seg_len;
      w.number = '0;
      w.gap    = '0;
      w.done   = 1'b1;
      return w;
    end
    num = (seg_base + i) & NUM_MASK;
    gap = (num >= last_prime) ? num - last_prime : 0;
    if (gap > GAP_MAX) gap = GAP_MAX;
    last_prime = num;
    scan_pos   = i + 1;
    w.number = num[NUMBER_WIDTH-1:0];
    w.gap    = gap[GAP_W-1:0];
    w.done   = 1'b0;
    return w;
  endfunction

  task automatic send_word(input op_e op, input logic [NUMBER_WIDTH-1:0] base,
                           input logic [LEN_W-1:0] len,
                           input logic [PRIME_WIDTH-1:0] prime);
    int unsigned idle;
    prime_word_t w;
    idle = no_idle ? 0 : $urandom_range(0, 3);
    if (idle != 0) begin
      in_if.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_if.opcode         <= op;
    in_if.segment_base   <= base;
    in_if.segment_length <= len;
    in_if.base_prime     <= prime;
    in_if.valid          <= 1'b1;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    case (op)
      OP_OPEN:   sieve_open(64'(base), 32'(len));
      OP_STRIKE: sieve_strike(64'(prime));
      OP_NEXT: begin
        w = sieve_next_prime();
        pending_primes.push_back(w);
        last_done = w.done;
      end
      default: ;
    endcase
    if (!(op == OP_NOP || (op == OP_STRIKE && prime < 2))) words_sent++;
  endtask

  // Open a segment and strike every base prime whose square can land in it.
  task automatic open_and_strike(input longint unsigned base, input int unsigned len);
    send_word(OP_OPEN, NUMBER_WIDTH'(base), LEN_W'(len), '0);
    foreach (small_primes[k]) begin
      if (longint'(small_primes[k]) * small_primes[k] < base + len) begin
        if ($urandom_range(0, 19) == 0) send_word(OP_NOP, '0, '0, '0);
        send_word(OP_STRIKE, '0, '0, PRIME_WIDTH'(small_primes[k]));
      end
    end
  endtask

  task automatic test_corner_cases();
    send_word(OP_NEXT, '0, '0, '0);          // empty after reset
    send_word(OP_NOP, '1, '1, '1);
    send_word(OP_OPEN, '0, 13'd30, '0);
    send_word(OP_STRIKE, '0, '0, 22'd0);
    send_word(OP_STRIKE, '0, '0, 22'd1);
    send_word(OP_STRIKE, '0, '0, 22'd2);
    send_word(OP_STRIKE, '0, '0, 22'd3);
    send_word(OP_STRIKE, '0, '0, 22'd5);
    send_word(OP_STRIKE, '0, '0, 22'd7);     // square past the end
    repeat (3) send_word(OP_NEXT, '0, '0, '0);
    send_word(OP_OPEN, 44'd100000000, 13'd8191, '0);  // length clamps
    send_word(OP_NEXT, '0, '0, '0);          // gap saturates
    send_word(OP_OPEN, 44'd10, 13'd5, '0);
    send_word(OP_NEXT, '0, '0, '0);          // below previous prime
    send_word(OP_OPEN, 44'd10000000000000, 13'd0, '0);
    repeat (2) send_word(OP_NEXT, '0, '0, '0);
    send_word(OP_OPEN, '1, 13'd4, '0);       // wraps through 0 and 1
    send_word(OP_STRIKE, '0, '0, '1);
    repeat (3) send_word(OP_NEXT, '0, '0, '0);
  endtask

  // Result side stalls long enough for the core to back up its input.
  task automatic test_backpressure();
    open_and_strike(1000, 200);
    hold_req = 1'b1;
    no_idle  = 1'b1;
    repeat (12) send_word(OP_NEXT, '0, '0, '0);
    no_idle  = 1'b0;
  endtask

  task automatic test_sieved_segments();
    longint unsigned base;
    longint unsigned prev_end;
    int unsigned     len;
    prev_end = 0;
    while (words_sent < SIEVED_WORDS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      len  = ($urandom_range(0, 9) == 0) ? SEGMENT_SIZE : $urandom_range(1, 400);
      base = $urandom_range(0, 1) ? 64'($urandom_range(0, 5000)) :
                                    64'($urandom_range(0, 200000));
      if ($urandom_range(0, 2) == 0 && prev_end + len < 4000000) base = prev_end;
      prev_end = base + len;
      open_and_strike(base, len);
      do send_word(OP_NEXT, '0, '0, '0); while (!last_done);
      if ($urandom_range(0, 2) == 0) send_word(OP_NEXT, '0, '0, '0);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_noise();
    logic [NUMBER_WIDTH-1:0] base;
    logic [LEN_W-1:0]        len;
    logic [PRIME_WIDTH-1:0]  prime;
    int unsigned             pick;
    while (words_sent < TOTAL_WORDS) begin
      if (words_sent % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      base[31:0]  = $urandom;
      base[43:32] = 12'($urandom_range(0, 4095));
      len   = LEN_W'($urandom_range(0, 1) ? $urandom_range(0, 8191) : $urandom_range(0, 64));
      prime = PRIME_WIDTH'(($urandom_range(0, 9) < 7) ? $urandom : $urandom_range(0, 60));
      pick  = $urandom_range(0, 99);
      if (pick < 12)      send_word(OP_OPEN, base, len, prime);
      else if (pick < 45) send_word(OP_STRIKE, base, len, prime);
      else if (pick < 90) send_word(OP_NEXT, base, len, prime);
      else                send_word(OP_NOP, base, len, prime);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    bit is_p;
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.opcode         = OP_NOP;
    in_if.segment_base   = '0;
    in_if.segment_length = '0;
    in_if.base_prime     = '0;
    seg_base   = 0;
    seg_len    = 0;
    scan_pos   = 0;
    last_prime = 0;
    words_sent = 0;
    mismatches = 0;
    last_done  = 1'b0;
    no_idle    = 1'b0;
    hold_req   = 1'b0;
    for (int unsigned n = 2; n < 2048; n++) begin
      is_p = 1'b1;
      for (int unsigned d = 2; d * d <= n; d++) if (n % d == 0) is_p = 1'b0;
      if (is_p) small_primes.push_back(n);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_cases();
    test_backpressure();
    test_sieved_segments();
    test_random_noise();

    in_if.valid <= 1'b0;
    while (pending_primes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result taker: random pauses per word, one long hold on request.
  initial begin
    int unsigned pause;
    out_if.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pause = HOLD_CYCLES;
      end else begin
        pause = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (pause != 0) begin
        out_if.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_primes.size() == 0) begin
        $error("unexpected result word: prime_number %0d", out_if.prime_number);
        mismatches++;
      end else begin
        want = pending_primes.pop_front();
        if (out_if.prime_number !== want.number) begin
          $error("prime_number: expected %0d, got %0d", want.number, out_if.prime_number);
          mismatches++;
        end
        if (out_if.prime_gap !== want.gap) begin
          $error("prime_gap: expected %0d, got %0d", want.gap, out_if.prime_gap);
          mismatches++;
        end
        if (out_if.segment_done !== want.done) begin
          $error("segment_done: expected %0d, got %0d", want.done, out_if.segment_done);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire
